>>> design/feba_pkg.sv
// ----------------------------------------------------------------------------
// feba_pkg
// Shared types and constants for the file extent bump allocator: command
// codes, controller states and the layout of one slot table entry.
// ----------------------------------------------------------------------------
package feba_pkg;

  localparam int LEN_W = 21;          // byte offsets, lengths and the mark
  localparam int SUM_W = LEN_W + 1;   // sums formed without wrap
  localparam int KEY_W = 32;

  typedef enum logic [1:0] {
    CMD_CREATE   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_WRITE    = 2'd2,
    CMD_TRUNCATE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } slot_entry_t;

endpackage

>>> design/feba_slot_ram.sv
// ----------------------------------------------------------------------------
// feba_slot_ram
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module feba_slot_ram
  import feba_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic        clk,
  input  logic        rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_entry_t rd_data,
  input  logic        wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_entry_t wr_data
);

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data when no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/file_extent_bump_allocator.sv
// ----------------------------------------------------------------------------
// file_extent_bump_allocator
// Each command scans the slot table one entry per cycle until it resolves on
// a slot or, on a miss, has compared all FILE_SLOTS entries; a new command
// transfers in only once the previous one has executed, and execute waits
// while an earlier result is unaccepted.
// Reset (rst, synchronous): all slots free, mark and live count zero,
// capacity 1048576. Table RAM contents are not cleared; no clearing pass.
// ----------------------------------------------------------------------------
//
// Keeps a table of file slots (key, offset, length) over a linear store and a
// bump mark giving the first free byte. Each command scans the slot table for
// a key match (delete, write, truncate) or for the first free slot (create),
// then applies the update in the execute state and loads the result register.
// The result register lets the next command transfer in while a result still
// waits on the output side.
module file_extent_bump_allocator
  import feba_pkg::*;
#(
  parameter int FILE_SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  // configuration: store capacity
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data,
  // command channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       command,
  input  logic [KEY_W-1:0] file_key,
  input  logic [LEN_W-1:0] size_req,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             ok,
  output logic [LEN_W-1:0] extent_offset,
  output logic [LEN_W-1:0] extent_length,
  output logic [LEN_W-1:0] used_bytes
);

  localparam int IDX_W = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int CNT_W = $clog2(FILE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(FILE_SLOTS);
  localparam logic [LEN_W-1:0] CAP_RESET  = LEN_W'(1048576);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t state, state_next;

  logic [LEN_W-1:0]      store_capacity;
  logic [LEN_W-1:0]      used_mark;
  logic [CNT_W-1:0]      live_count;
  logic [FILE_SLOTS-1:0] slot_valid;

  // latched command
  cmd_t             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [LEN_W-1:0] req_q;

  // scan pipeline: issue stage (scan_idx) and compare stage (cmp_*)
  logic [CNT_W-1:0] scan_idx;
  logic             cmp_pend;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_valid;

  // scan outcome
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  slot_entry_t      hit_entry;

  // table RAM ports
  logic        rd_en;
  slot_entry_t rd_data;
  logic        wr_en;
  slot_entry_t wr_data;

  logic hit_now;
  logic out_free;
  logic exec_fire;

  feba_slot_ram #(
    .DEPTH (FILE_SLOTS),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (hit_idx),
    .wr_data (wr_data)
  );

  // Create looks for a free slot; every other command for a live key match.
  assign hit_now = cmp_pend &&
                   ((cmd_q == CMD_CREATE) ? !cmp_valid
                                          : (cmp_valid && rd_data.key == key_q));

  // Result register can take a new value this cycle.
  assign out_free = !out_valid || out_ready;

  // The user is to write capacity only while idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Once every slot is issued the last compare is in flight now.
        if (hit_now || scan_idx == SLOT_COUNT) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    exec_fire = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        rd_en = (scan_idx != SLOT_COUNT) && !hit_now;
      end
      ST_EXEC: begin
        exec_fire = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Scan: issue one slot read per cycle, compare the previous one
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend  <= 1'b0;
      hit_found <= 1'b0;
    end else if (in_valid && in_ready) begin
      cmp_pend  <= 1'b0;
      hit_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      cmp_pend <= rd_en;
      if (hit_now) begin
        hit_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q    <= cmd_t'(command);
      key_q    <= file_key;
      req_q    <= size_req;
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      if (rd_en) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      cmp_idx   <= scan_idx[IDX_W-1:0];
      cmp_valid <= slot_valid[scan_idx[IDX_W-1:0]];
      if (hit_now) begin
        hit_idx   <= cmp_idx;
        hit_entry <= rd_data;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Execute: decide the command and form the new mark and table entry
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] create_end;
  logic [SUM_W-1:0] grow_end;
  logic [SUM_W-1:0] file_end;
  logic [SUM_W-1:0] cap_ext;
  logic             is_last;
  logic             res_ok;
  logic [LEN_W-1:0] res_off;
  logic [LEN_W-1:0] res_len;
  logic [LEN_W-1:0] mark_next;
  logic [CNT_W-1:0] live_next;
  logic             tbl_write;
  logic             valid_set;
  logic             valid_clr;

  always_comb begin
    create_end = SUM_W'(used_mark) + SUM_W'(req_q);
    grow_end   = SUM_W'(hit_entry.offset) + SUM_W'(req_q);
    file_end   = SUM_W'(hit_entry.offset) + SUM_W'(hit_entry.length);
    cap_ext    = SUM_W'(store_capacity);
    is_last    = (file_end == SUM_W'(used_mark));

    res_ok    = 1'b0;
    res_off   = '0;
    res_len   = '0;
    mark_next = used_mark;
    live_next = live_count;
    tbl_write = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    wr_data   = '{key: key_q, offset: used_mark, length: req_q};

    case (cmd_q)
      CMD_CREATE: begin
        if (hit_found && live_count < SLOT_COUNT && create_end <= cap_ext) begin
          res_ok    = 1'b1;
          res_off   = used_mark;
          res_len   = req_q;
          mark_next = create_end[LEN_W-1:0];
          live_next = live_count + CNT_W'(1);
          tbl_write = 1'b1;
          valid_set = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (hit_found) begin
          res_ok    = 1'b1;
          res_off   = hit_entry.offset;
          valid_clr = 1'b1;
          if (live_count != '0) begin
            live_next = live_count - CNT_W'(1);
          end
          // Pull the mark back when the file was last.
          if (is_last) begin
            mark_next = hit_entry.offset;
          end
        end
      end
      CMD_WRITE, CMD_TRUNCATE: begin
        wr_data = '{key: hit_entry.key, offset: hit_entry.offset, length: req_q};
        if (hit_found) begin
          if (req_q <= hit_entry.length) begin
            // Shrink in place; only truncate of the last file lowers the mark.
            res_ok    = 1'b1;
            res_off   = hit_entry.offset;
            res_len   = req_q;
            tbl_write = 1'b1;
            if (cmd_q == CMD_TRUNCATE && is_last) begin
              mark_next = grow_end[LEN_W-1:0];
            end
          end else if (is_last && grow_end <= cap_ext) begin
            // Grow only the last file, within capacity.
            res_ok    = 1'b1;
            res_off   = hit_entry.offset;
            res_len   = req_q;
            tbl_write = 1'b1;
            mark_next = grow_end[LEN_W-1:0];
          end
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign wr_en = exec_fire && tbl_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      used_mark      <= '0;
      live_count     <= '0;
      slot_valid     <= '0;
      store_capacity <= CAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        store_capacity <= cfg_data;
      end
      if (exec_fire) begin
        out_valid  <= 1'b1;
        used_mark  <= mark_next;
        live_count <= live_next;
        if (valid_set) begin
          slot_valid[hit_idx] <= 1'b1;
        end
        if (valid_clr) begin
          slot_valid[hit_idx] <= 1'b0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on execute, hold while stalled.
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      ok            <= res_ok;
      extent_offset <= res_off;
      extent_length <= res_len;
      used_bytes    <= mark_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_live_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'($countones(slot_valid)) == 32'(live_count))
    else $error("live count disagrees with slot valid bits");

  a_fail_zero_extent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> extent_offset == '0 && extent_length == '0)
    else $error("failed command reports a nonzero extent");

  a_exec_loads_result: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> out_valid && state == ST_IDLE)
    else $error("execute did not load the result register");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready)
    else $error("input ready while a command is in progress");

endmodule
